// ----- hw/rtl/fvsp_pkg.sv -----
// ---------------------------------------------------------------------------
// FASTA sentinel packer package
// Shared types, codes and character classes for the FASTA sentinel packer.
// ---------------------------------------------------------------------------
package fvsp_pkg;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_PRE   = 3'd1,
        PH_ID    = 3'd2,
        PH_REST  = 3'd3,
        PH_SEQ   = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        KIND_RESIDUE  = 3'd0,
        KIND_SENTINEL = 3'd1,
        KIND_ID       = 3'd2,
        KIND_RECORD   = 3'd3,
        KIND_DONE     = 3'd4,
        KIND_ERROR    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_INVALID_CHAR = 2'd0,
        ERR_EMPTY_HEADER = 2'd1,
        ERR_TOO_MANY     = 2'd2,
        ERR_NONE_FOUND   = 2'd3
    } t_err;

    typedef enum logic {
        REQ_TEXT = 1'b0,
        REQ_EOF  = 1'b1
    } t_req;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [7:0]  record_index;
        logic [31:0] record_start;
        logic [31:0] record_length;
        t_err        error_code;
        logic        last;
    } t_result;

    localparam logic [7:0] NUC_LIMIT = 8'd251;
    localparam logic [7:0] AA_LIMIT  = 8'd235;
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_GT     = 8'd62;
    localparam logic [7:0] CH_A      = 8'd65;
    localparam logic [7:0] CH_C      = 8'd67;
    localparam logic [7:0] CH_G      = 8'd71;
    localparam logic [7:0] CH_T      = 8'd84;
    localparam logic [7:0] CASE_GAP  = 8'd32;

    function automatic logic is_ws(input logic [7:0] b);
        logic r;
        r = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
        return r;
    endfunction

    function automatic logic is_nuc(input logic [7:0] b);
        logic r;
        r = (b == CH_A) || (b == CH_C) || (b == CH_G) || (b == CH_T);
        return r;
    endfunction

    // Amino acid letters: A, C..I, K..N, P..T, V, W, Y.
    function automatic logic is_aa(input logic [7:0] b);
        logic r;
        r = (b == 8'd65) || (b >= 8'd67 && b <= 8'd73) || (b >= 8'd75 && b <= 8'd78)
            || (b >= 8'd80 && b <= 8'd84) || (b == 8'd86) || (b == 8'd87)
            || (b == 8'd89);
        return r;
    endfunction

    function automatic logic is_letter(input logic mode, input logic [7:0] b);
        logic r;
        r = mode ? is_aa(b) : is_nuc(b);
        return r;
    endfunction

    // Index plus one, moved past any run of alphabet letters.
    function automatic logic [7:0] sentinel(input logic mode, input logic [7:0] idx);
        logic [7:0] s;
        s = idx + 8'd1;
        if (mode) begin
            if (s == 8'd65) begin
                s = 8'd66;
            end else if (s >= 8'd67 && s <= 8'd73) begin
                s = 8'd74;
            end else if (s >= 8'd75 && s <= 8'd78) begin
                s = 8'd79;
            end else if (s >= 8'd80 && s <= 8'd84) begin
                s = 8'd85;
            end else if (s == 8'd86 || s == 8'd87) begin
                s = 8'd88;
            end else if (s == 8'd89) begin
                s = 8'd90;
            end
        end else if (is_nuc(s)) begin
            s = s + 8'd1;
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/fasta_validating_sentinel_packer.sv -----
// Each result is written into the result queue when its request is accepted and is offered
// from the queue head. Throughput: one request per cycle while the queue has room; a request
// gives up to two results, which leave the queue one at a time, so the sustained rate follows the result count.
// A four-entry result queue decouples the sides; requests are taken while two slots are free.
// Reset is synchronous and active low; it clears all parser state and sets mode 0.
// ---------------------------------------------------------------------------
// FASTA sentinel packer
// Parses FASTA text bytes, validates residues and emits IDs, residues,
// record descriptors, sentinels and status results.
// ---------------------------------------------------------------------------
module fasta_validating_sentinel_packer #(
    parameter int POS_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_alphabet_mode,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_req_type,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_record_index,
    output logic [31:0] o_record_start,
    output logic [31:0] o_record_length,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};
    localparam logic [POS_WIDTH-1:0] POS_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

    logic                  r_mode;
    fvsp_pkg::t_phase      r_phase, n_phase;
    logic                  r_open, n_open;
    logic [POS_WIDTH-1:0]  r_res_cnt, n_res_cnt;
    logic [POS_WIDTH-1:0]  r_origin, n_origin;
    logic [POS_WIDTH-1:0]  r_out_pos, n_out_pos;
    logic [7:0]            r_rdone, n_rdone;
    logic                  r_err, n_err;

    fvsp_pkg::t_result     r_fifo [4];
    logic [1:0]            r_wr_ptr, r_rd_ptr;
    logic [2:0]            r_count, n_count;

    fvsp_pkg::t_result     res0, res1;
    logic [1:0]            res_n;
    logic                  in_acc, out_acc;
    logic                  rec_closing, hdr_ovf, is_eof;
    logic [7:0]            upc, rd_inc, rd_eof, limit;
    logic [POS_WIDTH-1:0]  pos_inc;
    logic [POS_WIDTH+31:0] origin_ext, cnt_ext;
    fvsp_pkg::t_result     head;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign o_in_ready  = (r_count <= 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign is_eof      = (i_req_type == fvsp_pkg::REQ_EOF);

    assign limit       = r_mode ? fvsp_pkg::AA_LIMIT : fvsp_pkg::NUC_LIMIT;
    assign rec_closing = r_open && (r_res_cnt != '0);
    assign hdr_ovf     = rec_closing && (r_rdone >= limit);
    assign rd_inc      = (r_rdone != 8'hFF) ? r_rdone + 8'd1 : r_rdone;
    assign pos_inc     = (r_out_pos != POS_MAX) ? r_out_pos + POS_ONE : r_out_pos;
    assign upc         = (i_in_byte >= 8'd97 && i_in_byte <= 8'd122)
                         ? i_in_byte - fvsp_pkg::CASE_GAP : i_in_byte;
    assign origin_ext  = {32'd0, r_origin};
    assign cnt_ext     = {32'd0, r_res_cnt};

    always_comb begin
        n_phase = r_phase;
        if (is_eof) begin
            n_phase = fvsp_pkg::PH_START;
        end else if (!r_err) begin
            case (r_phase)
                fvsp_pkg::PH_START: begin
                    if (i_in_byte == fvsp_pkg::CH_GT) begin
                        if (!hdr_ovf) begin
                            n_phase = fvsp_pkg::PH_PRE;
                        end
                    end else if (i_in_byte != fvsp_pkg::CH_NL) begin
                        n_phase = fvsp_pkg::PH_SEQ;
                    end
                end
                fvsp_pkg::PH_PRE: begin
                    if (!fvsp_pkg::is_ws(i_in_byte)) begin
                        n_phase = fvsp_pkg::PH_ID;
                    end
                end
                fvsp_pkg::PH_ID: begin
                    if (i_in_byte == fvsp_pkg::CH_NL) begin
                        n_phase = fvsp_pkg::PH_START;
                    end else if (fvsp_pkg::is_ws(i_in_byte)) begin
                        n_phase = fvsp_pkg::PH_REST;
                    end
                end
                fvsp_pkg::PH_REST, fvsp_pkg::PH_SEQ: begin
                    if (i_in_byte == fvsp_pkg::CH_NL) begin
                        n_phase = fvsp_pkg::PH_START;
                    end
                end
                default: begin
                    n_phase = fvsp_pkg::PH_START;
                end
            endcase
        end
    end

    always_comb begin
        res0      = '0;
        res1      = '0;
        res_n     = 2'd0;
        n_open    = r_open;
        n_res_cnt = r_res_cnt;
        n_origin  = r_origin;
        n_out_pos = r_out_pos;
        n_rdone   = r_rdone;
        n_err     = r_err;
        rd_eof    = rec_closing ? rd_inc : r_rdone;
        if (is_eof) begin
            if (!r_err) begin
                if (r_phase == fvsp_pkg::PH_PRE) begin
                    res0.kind       = fvsp_pkg::KIND_ERROR;
                    res0.error_code = fvsp_pkg::ERR_EMPTY_HEADER;
                    res_n           = 2'd1;
                end else begin
                    res1.kind          = (rd_eof == 8'd0) ? fvsp_pkg::KIND_ERROR
                                                          : fvsp_pkg::KIND_DONE;
                    res1.error_code    = (rd_eof == 8'd0) ? fvsp_pkg::ERR_NONE_FOUND
                                                          : fvsp_pkg::ERR_INVALID_CHAR;
                    res1.record_length = (rd_eof == 8'd0) ? 32'd0 : {24'd0, rd_eof};
                    if (rec_closing) begin
                        res0.kind          = fvsp_pkg::KIND_RECORD;
                        res0.record_index  = r_rdone;
                        res0.record_start  = origin_ext[31:0];
                        res0.record_length = cnt_ext[31:0];
                        res_n              = 2'd2;
                    end else begin
                        res0  = res1;
                        res_n = 2'd1;
                    end
                end
            end
            n_open    = 1'b0;
            n_res_cnt = '0;
            n_origin  = '0;
            n_out_pos = '0;
            n_rdone   = 8'd0;
            n_err     = 1'b0;
        end else if (!r_err) begin
            case (r_phase)
                fvsp_pkg::PH_START, fvsp_pkg::PH_SEQ: begin
                    if (i_in_byte == fvsp_pkg::CH_NL) begin
                        res_n = 2'd0;
                    end else if (i_in_byte == fvsp_pkg::CH_GT
                                 && r_phase == fvsp_pkg::PH_START) begin
                        if (rec_closing) begin
                            res0.kind          = fvsp_pkg::KIND_RECORD;
                            res0.record_index  = r_rdone;
                            res0.record_start  = origin_ext[31:0];
                            res0.record_length = cnt_ext[31:0];
                            res_n              = 2'd2;
                            n_rdone            = rd_inc;
                            if (hdr_ovf) begin
                                res1.kind       = fvsp_pkg::KIND_ERROR;
                                res1.error_code = fvsp_pkg::ERR_TOO_MANY;
                                n_err           = 1'b1;
                            end else begin
                                res1.kind         = fvsp_pkg::KIND_SENTINEL;
                                res1.out_byte     = fvsp_pkg::sentinel(r_mode, r_rdone);
                                res1.record_index = r_rdone;
                                n_out_pos         = pos_inc;
                                n_origin          = pos_inc;
                                n_res_cnt         = '0;
                            end
                        end else begin
                            n_origin  = r_out_pos;
                            n_res_cnt = '0;
                        end
                    end else if (!fvsp_pkg::is_ws(i_in_byte) && r_open) begin
                        res_n = 2'd1;
                        if (!fvsp_pkg::is_letter(r_mode, upc)) begin
                            res0.kind       = fvsp_pkg::KIND_ERROR;
                            res0.error_code = fvsp_pkg::ERR_INVALID_CHAR;
                            n_err           = 1'b1;
                        end else begin
                            res0.kind     = fvsp_pkg::KIND_RESIDUE;
                            res0.out_byte = upc;
                            n_out_pos     = pos_inc;
                            n_res_cnt     = (r_res_cnt != POS_MAX) ? r_res_cnt + POS_ONE
                                                                   : r_res_cnt;
                        end
                    end
                end
                fvsp_pkg::PH_PRE: begin
                    if (i_in_byte == fvsp_pkg::CH_NL) begin
                        res0.kind       = fvsp_pkg::KIND_ERROR;
                        res0.error_code = fvsp_pkg::ERR_EMPTY_HEADER;
                        res_n           = 2'd1;
                        n_err           = 1'b1;
                    end else if (!fvsp_pkg::is_ws(i_in_byte)) begin
                        res0.kind     = fvsp_pkg::KIND_ID;
                        res0.out_byte = i_in_byte;
                        res_n         = 2'd1;
                        n_open        = 1'b1;
                    end
                end
                fvsp_pkg::PH_ID: begin
                    if (!fvsp_pkg::is_ws(i_in_byte)) begin
                        res0.kind     = fvsp_pkg::KIND_ID;
                        res0.out_byte = i_in_byte;
                        res_n         = 2'd1;
                    end
                end
                default: begin
                    res_n = 2'd0;
                end
            endcase
        end
        if (res_n == 2'd1) begin
            res0.last = 1'b1;
        end else if (res_n == 2'd2) begin
            res1.last = 1'b1;
        end
    end

    always_comb begin
        n_count = r_count;
        if (in_acc) begin
            n_count = n_count + {1'b0, res_n};
        end
        if (out_acc) begin
            n_count = n_count - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_phase   <= fvsp_pkg::PH_START;
            r_open    <= 1'b0;
            r_res_cnt <= '0;
            r_origin  <= '0;
            r_out_pos <= '0;
            r_rdone   <= 8'd0;
            r_err     <= 1'b0;
            r_wr_ptr  <= 2'd0;
            r_rd_ptr  <= 2'd0;
            r_count   <= 3'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_alphabet_mode;
            end
            if (in_acc) begin
                r_phase   <= n_phase;
                r_open    <= n_open;
                r_res_cnt <= n_res_cnt;
                r_origin  <= n_origin;
                r_out_pos <= n_out_pos;
                r_rdone   <= n_rdone;
                r_err     <= n_err;
                r_wr_ptr  <= r_wr_ptr + res_n;
            end
            if (out_acc) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_n != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_acc && res_n == 2'd2) begin
            r_fifo[r_wr_ptr + 2'd1] <= res1;
        end
    end

    assign head            = r_fifo[r_rd_ptr];
    assign o_kind          = head.kind;
    assign o_out_byte      = head.out_byte;
    assign o_record_index  = head.record_index;
    assign o_record_start  = head.record_start;
    assign o_record_length = head.record_length;
    assign o_error_code    = head.error_code;
    assign o_last          = head.last;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("Result queue count out of range.");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[1:0])
        else $error("Result queue pointers disagree with the count.");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_eof |=> r_rdone == 8'd0 && !r_err && !r_open
                             && r_phase == fvsp_pkg::PH_START)
        else $error("End of file did not clear the parser state.");

    a_error_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && r_err |-> res_n == 2'd0)
        else $error("Results produced after an error.");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && res_n == 2'd2 |-> !res0.last && res1.last)
        else $error("Last flag misplaced on a two-result request.");

endmodule

// ----- tb/fasta_validating_sentinel_packer_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// FASTA sentinel packer testbench
// Feeds generated FASTA text and end-of-file requests through the packer and
// checks every result against a cycle-free model of the parser, with random
// stalls on both sides and alphabet mode changes between phases.
// ---------------------------------------------------------------------------
module fasta_validating_sentinel_packer_test;

    localparam int HANG_LIMIT   = 2000;
    localparam int RANDOM_CHUNK = 75;
    localparam logic [3:0][7:0] SEND_IDLE  = {8'd35, 8'd0, 8'd68, 8'd0};
    localparam logic [3:0][7:0] RECV_STALL = {8'd35, 8'd68, 8'd0, 8'd0};

    typedef struct {
        fvsp_pkg::t_req req;
        logic [7:0]     byt;
    } t_text_req;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_alphabet_mode = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_in_byte = 8'd0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [7:0]  o_record_index;
    logic [31:0] o_record_start;
    logic [31:0] o_record_length;
    logic [1:0]  o_error_code;
    logic        o_last;

    t_text_req         text_stream[$];
    fvsp_pkg::t_result awaited_results[$];
    fvsp_pkg::t_result step_results[$];
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;
    int                n_fail = 0;
    int                quiet_cycles = 0;

    logic             aa_mode;
    fvsp_pkg::t_phase ln_phase;
    logic             rec_open;
    logic             err_seen;
    logic [31:0]      res_cnt;
    logic [31:0]      rec_origin;
    logic [31:0]      out_pos;
    logic [7:0]       recs_done;

    fasta_validating_sentinel_packer uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_alphabet_mode (i_cfg_alphabet_mode),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_req_type          (i_req_type),
        .i_in_byte           (i_in_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_out_byte          (o_out_byte),
        .o_record_index      (o_record_index),
        .o_record_start      (o_record_start),
        .o_record_length     (o_record_length),
        .o_error_code        (o_error_code),
        .o_last              (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic ws_char(logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic alpha_char(logic mode, logic [7:0] b);
        string letters;
        logic hit;
        if (mode) begin
            letters = "ACDEFGHIKLMNPQRSTVWY";
        end else begin
            letters = "ACGT";
        end
        hit = 1'b0;
        for (int i = 0; i < letters.len(); i++) begin
            if (letters[i] == b) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [31:0] sat32(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic fvsp_pkg::t_result make_result(fvsp_pkg::t_kind k, logic [7:0] byt,
                                                      logic [7:0] idx, logic [31:0] start,
                                                      logic [31:0] len, fvsp_pkg::t_err e);
        fvsp_pkg::t_result r;
        r.kind          = k;
        r.out_byte      = byt;
        r.record_index  = idx;
        r.record_start  = start;
        r.record_length = len;
        r.error_code    = e;
        r.last          = 1'b0;
        return r;
    endfunction

    task log_step(fvsp_pkg::t_result r);
        step_results.insert(step_results.size(), r);
    endtask

    task clear_parse;
        ln_phase   = fvsp_pkg::PH_START;
        rec_open   = 1'b0;
        err_seen   = 1'b0;
        res_cnt    = 32'd0;
        rec_origin = 32'd0;
        out_pos    = 32'd0;
        recs_done  = 8'd0;
    endtask

    task raise_error(fvsp_pkg::t_err e);
        log_step(make_result(fvsp_pkg::KIND_ERROR, 8'd0, 8'd0, 32'd0, 32'd0, e));
        err_seen = 1'b1;
    endtask

    task open_header;
        logic [7:0] idx;
        logic [7:0] limit;
        logic [8:0] mark;
        if (rec_open && res_cnt != 32'd0) begin
            idx   = recs_done;
            limit = aa_mode ? fvsp_pkg::AA_LIMIT : fvsp_pkg::NUC_LIMIT;
            log_step(make_result(fvsp_pkg::KIND_RECORD, 8'd0, idx, rec_origin, res_cnt,
                                 fvsp_pkg::ERR_INVALID_CHAR));
            if (recs_done != 8'd255) begin
                recs_done = recs_done + 8'd1;
            end
            if (idx >= limit) begin
                raise_error(fvsp_pkg::ERR_TOO_MANY);
                return;
            end
            mark = {1'b0, idx} + 9'd1;
            while (alpha_char(aa_mode, mark[7:0])) begin
                mark = mark + 9'd1;
            end
            log_step(make_result(fvsp_pkg::KIND_SENTINEL, mark[7:0], idx, 32'd0, 32'd0,
                                 fvsp_pkg::ERR_INVALID_CHAR));
            out_pos = sat32(out_pos);
        end
        res_cnt    = 32'd0;
        rec_origin = out_pos;
        ln_phase   = fvsp_pkg::PH_PRE;
    endtask

    task take_residue(logic [7:0] b);
        logic [7:0] u;
        if (!ws_char(b) && rec_open) begin
            u = (b >= 8'd97 && b <= 8'd122) ? b - fvsp_pkg::CASE_GAP : b;
            if (!alpha_char(aa_mode, u)) begin
                raise_error(fvsp_pkg::ERR_INVALID_CHAR);
            end else begin
                log_step(make_result(fvsp_pkg::KIND_RESIDUE, u, 8'd0, 32'd0, 32'd0,
                                     fvsp_pkg::ERR_INVALID_CHAR));
                out_pos = sat32(out_pos);
                res_cnt = sat32(res_cnt);
            end
        end
    endtask

    task parse_request(fvsp_pkg::t_req req, logic [7:0] b);
        fvsp_pkg::t_result r;
        step_results.delete();
        if (req == fvsp_pkg::REQ_EOF) begin
            if (!err_seen) begin
                if (ln_phase == fvsp_pkg::PH_PRE) begin
                    raise_error(fvsp_pkg::ERR_EMPTY_HEADER);
                end else begin
                    if (rec_open && res_cnt != 32'd0) begin
                        log_step(make_result(fvsp_pkg::KIND_RECORD, 8'd0, recs_done,
                                             rec_origin, res_cnt,
                                             fvsp_pkg::ERR_INVALID_CHAR));
                        if (recs_done != 8'd255) begin
                            recs_done = recs_done + 8'd1;
                        end
                    end
                    if (recs_done == 8'd0) begin
                        raise_error(fvsp_pkg::ERR_NONE_FOUND);
                    end else begin
                        log_step(make_result(fvsp_pkg::KIND_DONE, 8'd0, 8'd0, 32'd0,
                                             {24'd0, recs_done},
                                             fvsp_pkg::ERR_INVALID_CHAR));
                    end
                end
            end
            clear_parse();
        end else if (!err_seen) begin
            case (ln_phase)
                fvsp_pkg::PH_START: begin
                    if (b == fvsp_pkg::CH_GT) begin
                        open_header();
                    end else if (b != fvsp_pkg::CH_NL) begin
                        ln_phase = fvsp_pkg::PH_SEQ;
                        take_residue(b);
                    end
                end
                fvsp_pkg::PH_PRE: begin
                    if (b == fvsp_pkg::CH_NL) begin
                        raise_error(fvsp_pkg::ERR_EMPTY_HEADER);
                    end else if (!ws_char(b)) begin
                        log_step(make_result(fvsp_pkg::KIND_ID, b, 8'd0, 32'd0, 32'd0,
                                             fvsp_pkg::ERR_INVALID_CHAR));
                        rec_open = 1'b1;
                        ln_phase = fvsp_pkg::PH_ID;
                    end
                end
                fvsp_pkg::PH_ID: begin
                    if (b == fvsp_pkg::CH_NL) begin
                        ln_phase = fvsp_pkg::PH_START;
                    end else if (ws_char(b)) begin
                        ln_phase = fvsp_pkg::PH_REST;
                    end else begin
                        log_step(make_result(fvsp_pkg::KIND_ID, b, 8'd0, 32'd0, 32'd0,
                                             fvsp_pkg::ERR_INVALID_CHAR));
                    end
                end
                fvsp_pkg::PH_REST: begin
                    if (b == fvsp_pkg::CH_NL) begin
                        ln_phase = fvsp_pkg::PH_START;
                    end
                end
                fvsp_pkg::PH_SEQ: begin
                    if (b == fvsp_pkg::CH_NL) begin
                        ln_phase = fvsp_pkg::PH_START;
                    end else begin
                        take_residue(b);
                    end
                end
                default: begin
                    ln_phase = fvsp_pkg::PH_START;
                end
            endcase
        end
        if (step_results.size() != 0) begin
            r = step_results[step_results.size() - 1];
            r.last = 1'b1;
            step_results[step_results.size() - 1] = r;
        end
        foreach (step_results[i]) begin
            awaited_results.insert(awaited_results.size(), step_results[i]);
        end
    endtask

    task flag(string what, longint unsigned want_v, longint unsigned got_v);
        n_fail++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want_v, got_v);
    endtask

    task check_result(fvsp_pkg::t_result got);
        fvsp_pkg::t_result want;
        if (awaited_results.size() == 0) begin
            n_fail++;
            $display("%0t: unexpected result, expected none, got kind %0d byte %0d",
                     $time, got.kind, got.out_byte);
            return;
        end
        want = awaited_results.pop_front();
        if (got.kind != want.kind) flag("kind", want.kind, got.kind);
        if (got.out_byte != want.out_byte) flag("out_byte", want.out_byte, got.out_byte);
        if (got.record_index != want.record_index) begin
            flag("record_index", want.record_index, got.record_index);
        end
        if (got.record_start != want.record_start) begin
            flag("record_start", want.record_start, got.record_start);
        end
        if (got.record_length != want.record_length) begin
            flag("record_length", want.record_length, got.record_length);
        end
        if (got.error_code != want.error_code) begin
            flag("error_code", want.error_code, got.error_code);
        end
        if (got.last != want.last) flag("last", want.last, got.last);
    endtask

    always @(posedge i_clk) begin : drive_requests
        t_text_req item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                parse_request(fvsp_pkg::t_req'(i_req_type), i_in_byte);
            end
            if (!i_in_valid || o_in_ready) begin
                if (text_stream.size() != 0 && int'($urandom_range(99)) >= send_idle_pct) begin
                    item = text_stream.pop_front();
                    i_in_valid <= 1'b1;
                    i_req_type <= item.req;
                    i_in_byte  <= item.byt;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_results
        fvsp_pkg::t_result got;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = {o_kind, o_out_byte, o_record_index, o_record_start, o_record_length,
                       o_error_code, o_last};
                check_result(got);
            end
            i_out_ready <= int'($urandom_range(99)) >= recv_stall_pct;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("fasta_validating_sentinel_packer verification failed");
            $finish;
        end
    end

    task add_byte(logic [7:0] b);
        t_text_req item;
        item.req = fvsp_pkg::REQ_TEXT;
        item.byt = b;
        text_stream.insert(text_stream.size(), item);
    endtask

    task add_eof;
        t_text_req item;
        item.req = fvsp_pkg::REQ_EOF;
        item.byt = 8'($urandom_range(255));
        text_stream.insert(text_stream.size(), item);
    endtask

    task add_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            add_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] id_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (ws_char(b)) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [7:0] any_byte_but(logic [7:0] skip);
        logic [7:0] b;
        b = 8'($urandom_range(255));
        while (b == skip || b == fvsp_pkg::CH_NL) begin
            b = 8'($urandom_range(255));
        end
        return b;
    endfunction

    function automatic logic [7:0] blank();
        logic [7:0] b;
        b = 8'($urandom_range(8, 13));
        if (b == 8'd8 || b == fvsp_pkg::CH_NL) begin
            b = 8'd32;
        end
        return b;
    endfunction

    function automatic logic [7:0] residue_char(logic aa);
        string letters;
        logic [7:0] c;
        if (aa) begin
            letters = "ACDEFGHIKLMNPQRSTVWY";
        end else begin
            letters = "ACGT";
        end
        c = letters[$urandom_range(letters.len() - 1)];
        if ($urandom_range(1) == 1) begin
            c = c + fvsp_pkg::CASE_GAP;
        end
        return c;
    endfunction

    task gen_noise;
        t_text_req item;
        repeat ($urandom_range(2, 10)) begin
            item.req = ($urandom_range(7) == 0) ? fvsp_pkg::REQ_EOF : fvsp_pkg::REQ_TEXT;
            item.byt = 8'($urandom_range(255));
            text_stream.insert(text_stream.size(), item);
        end
    endtask

    task gen_file(logic aa);
        int n_rec;
        int pick;
        if ($urandom_range(4) == 0) begin
            add_byte(any_byte_but(fvsp_pkg::CH_GT));
            repeat ($urandom_range(6)) add_byte(any_byte_but(fvsp_pkg::CH_NL));
            add_byte(fvsp_pkg::CH_NL);
        end
        n_rec = $urandom_range(4);
        repeat (n_rec) begin
            add_byte(fvsp_pkg::CH_GT);
            if ($urandom_range(3) == 0) add_byte(blank());
            if ($urandom_range(19) != 0) begin
                repeat ($urandom_range(1, 5)) add_byte(id_byte());
            end
            if ($urandom_range(2) == 0) begin
                add_byte(blank());
                repeat ($urandom_range(5)) add_byte(any_byte_but(fvsp_pkg::CH_NL));
            end
            add_byte(fvsp_pkg::CH_NL);
            repeat ($urandom_range(3)) begin
                repeat ($urandom_range(1, 10)) begin
                    pick = $urandom_range(199);
                    if (pick < 10) begin
                        add_byte(blank());
                    end else if (pick == 10) begin
                        add_byte(any_byte_but(fvsp_pkg::CH_NL));
                    end else if (pick == 11) begin
                        add_byte(residue_char(1'b1));
                    end else begin
                        add_byte(residue_char(aa));
                    end
                end
                if ($urandom_range(7) == 0) add_byte(8'd13);
                add_byte(fvsp_pkg::CH_NL);
                if ($urandom_range(9) == 0) add_byte(fvsp_pkg::CH_NL);
            end
        end
        pick = $urandom_range(9);
        if (pick == 9) begin
            add_byte(fvsp_pkg::CH_GT);
            add_eof();
        end else if (pick != 8) begin
            add_eof();
        end
    endtask

    task gen_traffic(logic aa, int amount);
        while (text_stream.size() < amount) begin
            if ($urandom_range(9) == 0) begin
                gen_noise();
            end else begin
                gen_file(aa);
            end
        end
    endtask

    task deep_records(int n);
        repeat (n) begin
            add_byte(fvsp_pkg::CH_GT);
            add_byte(id_byte());
            add_byte(fvsp_pkg::CH_NL);
            add_byte(residue_char(1'b0));
            add_byte(fvsp_pkg::CH_NL);
        end
    endtask

    task settle;
        @(negedge i_clk);
        while (text_stream.size() != 0 || i_in_valid || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task write_mode(logic m);
        i_cfg_valid         <= 1'b1;
        i_cfg_alphabet_mode <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        aa_mode = m;
    endtask

    initial begin
        aa_mode = 1'b0;
        clear_parse();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Text before the first header, an ID cut short by a description, mixed-case
        // residues with whitespace, an empty header, no records, and a stray '>'
        // on a line that starts with whitespace.
        add_str("z");
        add_byte(8'hFF);
        add_byte(fvsp_pkg::CH_NL);
        add_str("> a");
        add_byte(8'hFF);
        add_str(" x\n");
        add_str("c g\tT\n>\n");
        add_eof();
        add_eof();
        add_str(">b\n >");
        add_eof();
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            write_mode(~ph[0]);
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            gen_traffic(aa_mode, RANDOM_CHUNK);
            settle();
        end

        // A long file whose record indexes run through the sentinel values that
        // skip alphabet letters, switching the alphabet partway through.
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        add_eof();
        deep_records(70);
        settle();
        write_mode(1'b1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        deep_records(22);
        if ($urandom_range(1) == 0) add_byte(fvsp_pkg::CH_GT);
        add_eof();
        settle();

        if (n_fail == 0) begin
            $display("fasta_validating_sentinel_packer verification clean");
        end else begin
            $display("fasta_validating_sentinel_packer verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/fvsp_pkg.sv
hw/rtl/fasta_validating_sentinel_packer.sv
tb/fasta_validating_sentinel_packer_test.sv
